### sv/ess_pkg.sv
// Shared types, codes and constants of the encoder-set stopwatch controller.
`timescale 1ns / 1ps
`default_nettype none

package ess_pkg;

   // Event codes carried in the request tuser field
   localparam logic [1:0] OP_TICK    = 2'd0;
   localparam logic [1:0] OP_BUTTON  = 2'd1;
   localparam logic [1:0] OP_ENCODER = 2'd2;

   // Operating modes
   localparam logic [1:0] MODE_START     = 2'd0;
   localparam logic [1:0] MODE_CONFIGURE = 2'd1;
   localparam logic [1:0] MODE_COUNT     = 2'd2;

   // Register indexes on the CSR port
   localparam logic CSR_TICK_INTERVAL = 1'b0;
   localparam logic CSR_DEBOUNCE      = 1'b1;

   // Register reset values
   localparam logic [15:0] TICK_INTERVAL_RESET = 16'd1000;
   localparam logic [15:0] DEBOUNCE_RESET      = 16'd200;

   // Counter limits
   localparam logic [12:0] ELAPSED_MAX    = 13'd5999;
   localparam logic [8:0]  SETPOINT_MAX   = 9'd399;
   localparam logic [8:0]  SETPOINT_UNDER = 9'd396;

   // Quadrature history patterns {old b, old a, new b, new a}
   localparam logic [3:0] QUAD_UP_A   = 4'b1101;
   localparam logic [3:0] QUAD_UP_B   = 4'b0100;
   localparam logic [3:0] QUAD_UP_C   = 4'b0010;
   localparam logic [3:0] QUAD_UP_D   = 4'b1011;
   localparam logic [3:0] QUAD_DOWN_A = 4'b1110;
   localparam logic [3:0] QUAD_DOWN_B = 4'b0111;
   localparam logic [3:0] QUAD_DOWN_C = 4'b0001;
   localparam logic [3:0] QUAD_DOWN_D = 4'b1000;

   // One input event
   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] now_ms;
      logic        pin_a;
      logic        pin_b;
   } event_type;

   // One result, fields in output order
   typedef struct packed {
      logic [1:0]  mode;
      logic        flash_on;
      logic [12:0] elapsed_seconds;
      logic [3:0]  minute_tens;
      logic [3:0]  minute_units;
      logic [2:0]  second_tens;
      logic [3:0]  second_units;
      logic [8:0]  setpoint_quarters;
      logic [3:0]  setpoint_tens;
      logic [3:0]  setpoint_units;
   } result_type;

   // Full controller state: visible fields plus timestamps and encoder history
   typedef struct packed {
      result_type  res;
      logic [31:0] last_tick_ms;
      logic [31:0] last_button_ms;
      logic [3:0]  quad_history;
   } state_type;

endpackage

`default_nettype wire

### sv/ess_core.sv
// State registers and combinational event update of the stopwatch controller.
`timescale 1ns / 1ps
`default_nettype none

module ess_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire ess_pkg::event_type ev,
   input  wire logic [15:0]        tick_interval,
   input  wire logic [15:0]        debounce,
   output ess_pkg::result_type     res_next
);

   ess_pkg::state_type state_ff;
   ess_pkg::state_type state_in;

   logic [31:0] tick_gap;
   logic [31:0] button_gap;
   logic        tick_due;
   logic        button_ok;
   logic [3:0]  quad_new;

   // Elapsed times since the last acted tick and the last button edge
   assign tick_gap   = ev.now_ms - state_ff.last_tick_ms;
   assign button_gap = ev.now_ms - state_ff.last_button_ms;
   assign tick_due   = tick_gap > {16'd0, tick_interval};
   assign button_ok  = button_gap > {16'd0, debounce};
   assign quad_new   = {state_ff.quad_history[1:0], ev.pin_b, ev.pin_a};

   // Next state; digits are kept as decimal counters alongside the binary values
   always_comb begin
      state_in = state_ff;
      unique case (ev.opcode)
         ess_pkg::OP_TICK: begin
            if (tick_due && state_ff.res.mode == ess_pkg::MODE_START) begin
               state_in.res.flash_on = ~state_ff.res.flash_on;
               state_in.last_tick_ms = ev.now_ms;
            end else if (tick_due && state_ff.res.mode == ess_pkg::MODE_COUNT) begin
               state_in.last_tick_ms = ev.now_ms;
               if (state_ff.res.elapsed_seconds != ess_pkg::ELAPSED_MAX) begin
                  state_in.res.elapsed_seconds = state_ff.res.elapsed_seconds + 13'd1;
                  if (state_ff.res.second_units != 4'd9) begin
                     state_in.res.second_units = state_ff.res.second_units + 4'd1;
                  end else begin
                     state_in.res.second_units = 4'd0;
                     if (state_ff.res.second_tens != 3'd5) begin
                        state_in.res.second_tens = state_ff.res.second_tens + 3'd1;
                     end else begin
                        state_in.res.second_tens = 3'd0;
                        if (state_ff.res.minute_units != 4'd9) begin
                           state_in.res.minute_units = state_ff.res.minute_units + 4'd1;
                        end else begin
                           state_in.res.minute_units = 4'd0;
                           state_in.res.minute_tens  = state_ff.res.minute_tens + 4'd1;
                        end
                     end
                  end
               end
            end
         end
         ess_pkg::OP_BUTTON: begin
            state_in.last_button_ms = ev.now_ms;
            if (button_ok) begin
               unique case (state_ff.res.mode)
                  ess_pkg::MODE_START:     state_in.res.mode = ess_pkg::MODE_CONFIGURE;
                  ess_pkg::MODE_CONFIGURE: state_in.res.mode = ess_pkg::MODE_COUNT;
                  ess_pkg::MODE_COUNT: begin
                     state_in.res.mode              = ess_pkg::MODE_START;
                     state_in.res.elapsed_seconds   = 13'd0;
                     state_in.res.minute_tens       = 4'd0;
                     state_in.res.minute_units      = 4'd0;
                     state_in.res.second_tens       = 3'd0;
                     state_in.res.second_units      = 4'd0;
                     state_in.res.setpoint_quarters = 9'd0;
                     state_in.res.setpoint_tens     = 4'd0;
                     state_in.res.setpoint_units    = 4'd0;
                  end
                  default: state_in.res.mode = state_ff.res.mode;
               endcase
            end
         end
         ess_pkg::OP_ENCODER: begin
            if (state_ff.res.mode == ess_pkg::MODE_CONFIGURE) begin
               state_in.quad_history = quad_new;
               case (quad_new) inside
                  ess_pkg::QUAD_UP_A, ess_pkg::QUAD_UP_B,
                  ess_pkg::QUAD_UP_C, ess_pkg::QUAD_UP_D: begin
                     // Step up; 100.00 wraps to zero
                     if (state_ff.res.setpoint_quarters == ess_pkg::SETPOINT_MAX) begin
                        state_in.res.setpoint_quarters = 9'd0;
                        state_in.res.setpoint_tens     = 4'd0;
                        state_in.res.setpoint_units    = 4'd0;
                     end else begin
                        state_in.res.setpoint_quarters =
                           state_ff.res.setpoint_quarters + 9'd1;
                        if (state_ff.res.setpoint_quarters[1:0] == 2'd3) begin
                           if (state_ff.res.setpoint_units != 4'd9) begin
                              state_in.res.setpoint_units =
                                 state_ff.res.setpoint_units + 4'd1;
                           end else begin
                              state_in.res.setpoint_units = 4'd0;
                              state_in.res.setpoint_tens  =
                                 state_ff.res.setpoint_tens + 4'd1;
                           end
                        end
                     end
                  end
                  ess_pkg::QUAD_DOWN_A, ess_pkg::QUAD_DOWN_B,
                  ess_pkg::QUAD_DOWN_C, ess_pkg::QUAD_DOWN_D: begin
                     // Step down; below zero becomes 99.00
                     if (state_ff.res.setpoint_quarters == 9'd0) begin
                        state_in.res.setpoint_quarters = ess_pkg::SETPOINT_UNDER;
                        state_in.res.setpoint_tens     = 4'd9;
                        state_in.res.setpoint_units    = 4'd9;
                     end else begin
                        state_in.res.setpoint_quarters =
                           state_ff.res.setpoint_quarters - 9'd1;
                        if (state_ff.res.setpoint_quarters[1:0] == 2'd0) begin
                           if (state_ff.res.setpoint_units != 4'd0) begin
                              state_in.res.setpoint_units =
                                 state_ff.res.setpoint_units - 4'd1;
                           end else begin
                              state_in.res.setpoint_units = 4'd9;
                              state_in.res.setpoint_tens  =
                                 state_ff.res.setpoint_tens - 4'd1;
                           end
                        end
                     end
                  end
                  default: state_in.quad_history = quad_new;
               endcase
            end
         end
         default: state_in = state_ff;
      endcase
   end

   // State register, updated once per processed request
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   assign res_next = state_in.res;

endmodule

`default_nettype wire

### sv/encoder_set_stopwatch_controller_core.sv
// Top level: request register, configuration registers and result register.
`timescale 1ns / 1ps
`default_nettype none

// Stopwatch controller with start, configure and count modes. Each request is
// one event (time tick, button rising edge or encoder pin change) and yields
// exactly one response carrying the mode, flash phase, elapsed seconds with
// mm:ss digits, and the setpoint in quarters with its two integer digits.
// Throughput is one request per clock while the response side keeps up; a
// request is captured in the input register, its state update is made as it
// moves from that register into the result register, and the response is
// presented from the result register. A stalled response holds the
// request register, then the input. The timing path is the 32-bit
// timestamp subtract and compare in the update.
// CSR writes should be made only while no request is in flight.
module encoder_set_stopwatch_controller_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // now_ms[31:0], pin_a[32], pin_b[33], zero pad
   input  wire logic [1:0]  req_tuser,   // opcode[1:0]
   // Response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // mode[1:0], flash_on[2], elapsed_seconds[15:3],
                                         // minute_tens[19:16], minute_units[23:20],
                                         // second_tens[26:24], second_units[30:27],
                                         // setpoint_quarters[39:31], setpoint_tens[43:40],
                                         // setpoint_units[47:44]
   // CSR write port
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata
);

   logic                in_valid_ff;
   ess_pkg::event_type  ev_ff;
   logic                rsp_valid_ff;
   ess_pkg::result_type res_ff;
   ess_pkg::result_type res_next;
   logic [15:0]         tick_interval_ff;
   logic [15:0]         debounce_ff;
   logic                advance;

   // Move the held request into the result register when that slot is free
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // Request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         ev_ff.opcode <= req_tuser;
         ev_ff.now_ms <= req_tdata[31:0];
         ev_ff.pin_a  <= req_tdata[32];
         ev_ff.pin_b  <= req_tdata[33];
      end
   end

   // CSR registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_interval_ff <= ess_pkg::TICK_INTERVAL_RESET;
         debounce_ff      <= ess_pkg::DEBOUNCE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            ess_pkg::CSR_TICK_INTERVAL: tick_interval_ff <= csr_wdata;
            ess_pkg::CSR_DEBOUNCE:      debounce_ff      <= csr_wdata;
         endcase
      end
   end

   ess_core u_core (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .ev            (ev_ff),
      .tick_interval (tick_interval_ff),
      .debounce      (debounce_ff),
      .res_next      (res_next)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= res_next;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {res_ff.setpoint_units, res_ff.setpoint_tens,
                        res_ff.setpoint_quarters, res_ff.second_units,
                        res_ff.second_tens, res_ff.minute_units, res_ff.minute_tens,
                        res_ff.elapsed_seconds, res_ff.flash_on, res_ff.mode};

endmodule

`default_nettype wire
